@@ sv/bts_pkg.sv @@
// Package for the bitmask task scheduler: event codes, sleep constants and the
// command and status structs between controller and datapath. No dependencies.
package bts_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned ID_W = 5;
  localparam int unsigned TICKS_W = 32;

  // Event codes carried in the kind field; codes 6 and 7 are ignored.
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_YIELD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SLEEP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd5;

  localparam logic [TICKS_W-1:0] SLEEP_FOREVER = 32'hFFFF_FFFF;
  localparam logic [TICKS_W-1:0] SLEEP_NONE    = 32'h0000_0000;

  localparam logic [ID_W-1:0] IDLE_TASK = 5'd0;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  // Controller to datapath: one strobe per kind of work.
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic tick_step;  // one step of the sleep counter walk
    logic apply;      // apply the kernel call to the task sets
    logic sched;      // pick the next running task
    logic out_load;   // load the result register
  } bts_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              tick_last;
  } bts_stat_t;

endpackage

@@ sv/bts_req_if.sv @@
// Request channel of the bitmask task scheduler: one kernel event per item.
// Depends on nothing.
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  target_task;
  logic [31:0] sleep_ticks;
  logic        start_suspended;

  modport source (output valid, kind, target_task, sleep_ticks, start_suspended,
                  input ready);
  modport sink (input valid, kind, target_task, sleep_ticks, start_suspended,
                output ready);
endinterface

@@ sv/bts_rsp_if.sv @@
// Result channel of the bitmask task scheduler: one result item per event.
// Depends on nothing.
interface bts_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] running_task;
  logic [4:0] created_task;
  logic       status;

  modport source (output valid, running_task, created_task, status, input ready);
  modport sink (input valid, running_task, created_task, status, output ready);
endinterface

@@ sv/bitmask_task_scheduler.sv @@
// Bitmask task scheduler: one kernel event in, one result item out.
// Tick: walks the sleep counter RAM, one slot per cycle with the read pipelined,
// then schedules and loads the result register.
// Yield, sleep, exit: apply, schedule, load. Resume, create, unused codes: apply, load.
// Reset (rst, synchronous, active high) empties all task sets and runs the idle task;
// the sleep counters are not cleared, each is written when its task goes to sleep.
module bitmask_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst,
  bts_req_if.sink      req,
  bts_rsp_if.source    rsp
);

  bts_pkg::bts_cmd_t  cmd;
  bts_pkg::bts_stat_t st;

  // Controller: accepts an item only while idle, but the result register lets
  // the next item in while the previous result still waits on rsp.
  bts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: holds the ready, round, sleep, suspend and exist masks, the
  // running task and the per-task sleep counters; the schedule step picks the
  // lowest task left in the round, refilling the round from the ready set.
  bts_dpath #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_kind     (req.kind),
    .in_target   (req.target_task),
    .in_ticks    (req.sleep_ticks),
    .in_susp     (req.start_suspended),
    .st          (st),
    .running_task(rsp.running_task),
    .created_task(rsp.created_task),
    .status      (rsp.status)
  );

endmodule

@@ sv/bts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bts_ctrl.sv @@
// Controller of the bitmask task scheduler: sequences tick walk, call, schedule
// and result load. Depends on bts_pkg.
module bts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bts_pkg::bts_stat_t st,
  output bts_pkg::bts_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_APPLY,
    S_SCHED,
    S_DONE
  } state_t;

  state_t state;
  logic   resched;

  assign resched = (st.kind == bts_pkg::KIND_YIELD) || (st.kind == bts_pkg::KIND_SLEEP) ||
                   (st.kind == bts_pkg::KIND_EXIT);

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.latch     = (state == S_IDLE) && in_valid;
    cmd.tick_step = (state == S_TICK);
    cmd.apply     = (state == S_APPLY);
    cmd.sched     = (state == S_SCHED);
    cmd.out_load  = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_kind == bts_pkg::KIND_TICK) ? S_TICK : S_APPLY;
          end
        end
        S_TICK: begin
          if (st.tick_last) begin
            state <= S_SCHED;
          end
        end
        S_APPLY: begin
          state <= resched ? S_SCHED : S_DONE;
        end
        S_SCHED: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/bts_dpath.sv @@
// Datapath of the bitmask task scheduler: task sets, running task, sleep
// counter RAM and result register. Depends on bts_pkg and bts_ram.
module bts_dpath #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bts_pkg::bts_cmd_t  cmd,
  input  logic [2:0]         in_kind,
  input  logic [4:0]         in_target,
  input  logic [31:0]        in_ticks,
  input  logic               in_susp,
  output bts_pkg::bts_stat_t st,
  output logic [4:0]         running_task,
  output logic [4:0]         created_task,
  output logic               status
);

  localparam int unsigned IDXW = $clog2(TASK_SLOTS);
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [TASK_SLOTS-1:0] ONE = TASK_SLOTS'(1);

  logic [TASK_SLOTS-1:0] ready_set;
  logic [TASK_SLOTS-1:0] round_set;
  logic [TASK_SLOTS-1:0] sleep_set;
  logic [TASK_SLOTS-1:0] suspend_set;
  logic [TASK_SLOTS-1:0] exist_set;
  logic [4:0]            running_id;

  logic [2:0]  kind_q;
  logic [4:0]  target_q;
  logic [31:0] ticks_q;
  logic        susp_q;
  logic [4:0]  created_q;
  logic        status_q;
  logic [CW-1:0] cnt;

  function automatic logic [4:0] lowest(input logic [TASK_SLOTS-1:0] m);
    logic [4:0] r;
    r = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  logic [TASK_SLOTS-1:0] cur_bit, tgt_bit, free_set, free_bit;
  logic [TASK_SLOTS-1:0] round_live, round_base;
  logic [4:0]            free_id, pick;
  logic [CW-1:0]         pidx_full;
  logic [IDXW-1:0]       pidx;
  logic                  walk_hit;
  logic [31:0]           rdata, dec;
  logic                  wake;
  logic                  sleep_wr;
  logic                  we;
  logic [IDXW-1:0]       waddr;
  logic [31:0]           wdata;

  assign cur_bit  = ONE << running_id;
  assign tgt_bit  = ONE << target_q;        // zero for targets beyond the slots
  assign free_set = ~exist_set & ~ONE;      // the idle slot is never free
  assign free_id  = lowest(free_set);
  assign free_bit = ONE << free_id;

  assign round_live = round_set & ready_set;
  assign round_base = (round_live == '0) ? ready_set : round_live;
  assign pick       = lowest(round_base);

  // Counter walk: read slot cnt while slot cnt-1 comes back from the RAM.
  assign pidx_full = cnt - CW'(1);
  assign pidx      = pidx_full[IDXW-1:0];
  assign walk_hit  = cmd.tick_step && (cnt != '0) && sleep_set[pidx];
  assign dec       = (rdata != '0) ? rdata - 32'd1 : '0;
  assign wake      = (dec == '0);

  assign sleep_wr = cmd.apply && (kind_q == bts_pkg::KIND_SLEEP) &&
                    (running_id != bts_pkg::IDLE_TASK) &&
                    (ticks_q != bts_pkg::SLEEP_NONE) && (ticks_q != bts_pkg::SLEEP_FOREVER);

  // Resume leaves the counter alone: a counter is read only while its task
  // sleeps, and every sleep writes it first.
  always_comb begin
    we    = walk_hit || sleep_wr;
    waddr = sleep_wr ? running_id[IDXW-1:0] : pidx;
    wdata = sleep_wr ? ticks_q : dec;
  end

  bts_ram #(
    .WIDTH(32),
    .DEPTH(TASK_SLOTS)
  ) u_counts (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[IDXW-1:0]),
    .rdata(rdata)
  );

  assign st.kind      = kind_q;
  assign st.tick_last = (cnt == CW'(TASK_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_set    <= '0;
      round_set    <= '0;
      sleep_set    <= '0;
      suspend_set  <= '0;
      exist_set    <= '0;
      running_id   <= bts_pkg::IDLE_TASK;
      cnt          <= '0;
      kind_q       <= bts_pkg::KIND_TICK;
      target_q     <= '0;
      ticks_q      <= '0;
      susp_q       <= 1'b0;
      created_q    <= '0;
      status_q     <= bts_pkg::STATUS_OK;
      running_task <= '0;
      created_task <= '0;
      status       <= bts_pkg::STATUS_OK;
    end else begin
      if (cmd.latch) begin
        kind_q    <= in_kind;
        target_q  <= in_target;
        ticks_q   <= in_ticks;
        susp_q    <= in_susp;
        created_q <= '0;
        status_q  <= bts_pkg::STATUS_OK;
        cnt       <= '0;
      end
      if (cmd.tick_step) begin
        cnt <= cnt + CW'(1);
        if (walk_hit && wake) begin
          sleep_set[pidx] <= 1'b0;
          ready_set[pidx] <= 1'b1;
          round_set[pidx] <= 1'b1;
        end
      end
      if (cmd.apply) begin
        unique case (kind_q) inside
          bts_pkg::KIND_YIELD, bts_pkg::KIND_SLEEP: begin
            if (running_id != bts_pkg::IDLE_TASK) begin
              if (kind_q == bts_pkg::KIND_SLEEP && ticks_q != bts_pkg::SLEEP_NONE) begin
                ready_set <= ready_set & ~cur_bit;
                if (ticks_q == bts_pkg::SLEEP_FOREVER) begin
                  suspend_set <= suspend_set | cur_bit;
                end else begin
                  sleep_set <= sleep_set | cur_bit;
                end
              end
              round_set <= round_set & ~cur_bit;
            end
          end
          bts_pkg::KIND_EXIT: begin
            if (running_id != bts_pkg::IDLE_TASK) begin
              ready_set   <= ready_set & ~cur_bit;
              round_set   <= round_set & ~cur_bit;
              sleep_set   <= sleep_set & ~cur_bit;
              suspend_set <= suspend_set & ~cur_bit;
              exist_set   <= exist_set & ~cur_bit;
            end
          end
          bts_pkg::KIND_RESUME: begin
            if (target_q != bts_pkg::IDLE_TASK && (exist_set & tgt_bit) != '0) begin
              sleep_set   <= sleep_set & ~tgt_bit;
              suspend_set <= suspend_set & ~tgt_bit;
              ready_set   <= ready_set | tgt_bit;
              round_set   <= round_set | tgt_bit;
            end
          end
          bts_pkg::KIND_CREATE: begin
            if (free_set == '0) begin
              status_q <= bts_pkg::STATUS_NO_SLOT;
            end else begin
              exist_set <= exist_set | free_bit;
              sleep_set <= sleep_set & ~free_bit;
              if (susp_q) begin
                suspend_set <= suspend_set | free_bit;
                ready_set   <= ready_set & ~free_bit;
                round_set   <= round_set & ~free_bit;
              end else begin
                suspend_set <= suspend_set & ~free_bit;
                ready_set   <= ready_set | free_bit;
                round_set   <= round_set | free_bit;
              end
              created_q <= free_id;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.sched) begin
        if (ready_set == '0) begin
          running_id <= bts_pkg::IDLE_TASK;
          round_set  <= '0;
        end else begin
          running_id <= pick;
          round_set  <= round_base & ~(ONE << pick);
        end
      end
      if (cmd.out_load) begin
        running_task <= running_id;
        created_task <= created_q;
        status       <= status_q;
      end
    end
  end

endmodule

@@ sv/bts_checker.sv @@
// Port-level checker for the bitmask task scheduler, bound to the top level.
// Depends on bitmask_task_scheduler and bts_pkg.
module bts_checker #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [4:0] running_task,
  input logic [4:0] created_task,
  input logic       status
);

  // Hold a stalled result.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({running_task, created_task, status}))
    else $error("stalled result changed");

  // One item at a time: an accept drops ready in the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

  // A failed create reports no slot.
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bts_pkg::STATUS_NO_SLOT |-> created_task == '0)
    else $error("failed create returned a slot");

  // Task numbers stay inside the slot range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(running_task) < TASK_SLOTS) && (32'(created_task) < TASK_SLOTS))
    else $error("task number outside slot range");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind bitmask_task_scheduler bts_checker #(
  .TASK_SLOTS(TASK_SLOTS)
) u_bts_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .running_task(rsp.running_task),
  .created_task(rsp.created_task),
  .status      (rsp.status)
);
